@@ sv/range_and_farthest_end_search_unit_assert.svh @@
// assertion macros for the range and farthest end search unit
`ifndef RANGE_AND_FARTHEST_END_SEARCH_UNIT_ASSERT_SVH
`define RANGE_AND_FARTHEST_END_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RAFES_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rafes assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RAFES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rafes assertion failed");

`endif

@@ sv/rafes_pkg.sv @@
// shared constants and types for the range and farthest end search unit
`timescale 1ns / 1ps

package rafes_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int VALUE_BITS = 32;

    // fixed field widths of the channels
    localparam int DATA_W  = 32;
    localparam int START_W = 11;
    localparam int MODE_W  = 2;

    // row index and per-bit count width
    localparam int IDX_W = $clog2(MAX_ITEMS + 1);
    // width that holds both a row index and a start index
    localparam int IXW   = (IDX_W > START_W) ? IDX_W : START_W;
    // width for the threshold compare
    localparam int CMP_W = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;

    // command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QFILL_W = $clog2(QDEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_NEW    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_APPEND,
        CMD_QUERY
    } cmd_e;

    typedef logic [VALUE_BITS-1:0][IDX_W-1:0] row_t;

    typedef struct packed {
        cmd_e               kind;
        logic [DATA_W-1:0]  value;
        logic [START_W-1:0] start;
        logic [DATA_W-1:0]  threshold;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_out_t;

    typedef struct packed {
        logic               valid;
        logic               found;
        logic [START_W-1:0] end_index;
    } res_t;

endpackage

@@ sv/rafes_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps

interface rafes_req_if;
    import rafes_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [DATA_W-1:0]  value;
    logic [START_W-1:0] start_index;
    logic [DATA_W-1:0]  threshold;

    modport source (output valid, mode, value, start_index, threshold, input ready);
    modport sink   (input valid, mode, value, start_index, threshold, output ready);
endinterface

interface rafes_rsp_if;
    import rafes_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [START_W-1:0] end_index;

    modport source (output valid, found, end_index, input ready);
    modport sink   (input valid, found, end_index, output ready);
endinterface

@@ sv/range_and_farthest_end_search_unit.sv @@
// top level of the range and farthest end search unit
//
//  channel | role   | handshake   | payload
//  --------+--------+-------------+-----------------------------------------
//  req     | sink   | valid/ready | mode, value, start_index, threshold
//  rsp     | source | valid/ready | found, end_index
//
// new-array and append transactions are taken in the idle state and give
// no response; a query with a start outside 1..count goes straight to done;
// any other query reads the base row, then makes P = ceil(log2(count - start + 1)) + 1
// probes of the single store read port, 11 probes over 1024 values
// reset clears the count and control state; row zero reads as zeros, no clearing pass
// a two-entry command queue and the response register let each side stall on its own
`timescale 1ns / 1ps

module range_and_farthest_end_search_unit (
    input  logic        clk,
    input  logic        rst_n,
    rafes_req_if.sink   req,
    rafes_rsp_if.source rsp
);
    import rafes_pkg::*;

    q_out_t q;
    logic   pop;
    res_t   res;
    logic   res_ready;

    logic               rsp_valid_reg;
    logic               rsp_found_reg;
    logic [START_W-1:0] rsp_end_reg;

    // front end: classify and queue
    rafes_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .q     (q),
        .pop   (pop)
    );

    // back end: store and search
    rafes_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .pop       (pop),
        .res       (res),
        .res_ready (res_ready)
    );

    // response register is free when empty or being drained this cycle
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res.valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // payload only loads on a hand-over from the back end
    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            rsp_found_reg <= res.found;
            rsp_end_reg   <= res.end_index;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.found     = rsp_found_reg;
    assign rsp.end_index = rsp_end_reg;

endmodule

@@ sv/rafes_front.sv @@
// front end: accepts request transactions, classifies them, queues commands
`timescale 1ns / 1ps

module rafes_front (
    input  logic            clk,
    input  logic            rst_n,
    rafes_req_if.sink       req,
    output rafes_pkg::q_out_t q,
    input  logic            pop
);
    import rafes_pkg::*;

    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;

    cmd_t cmd_in;
    logic is_cmd;
    logic push;

    always_comb
    begin
        cmd_in.value     = req.value;
        cmd_in.start     = req.start_index;
        cmd_in.threshold = req.threshold;
        is_cmd           = 1'b1;
        case (req.mode)
            MODE_NEW:    cmd_in.kind = CMD_CLEAR;
            MODE_APPEND: cmd_in.kind = CMD_APPEND;
            MODE_QUERY:  cmd_in.kind = CMD_QUERY;
            default:
            begin
                // unused mode is dropped
                cmd_in.kind = CMD_CLEAR;
                is_cmd      = 1'b0;
            end
        endcase
    end

    assign req.ready = (fill_reg != QFILL_W'(QDEPTH));
    assign push      = req.valid && req.ready && is_cmd;

    assign q.valid = (fill_reg != '0);
    assign q.cmd   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ sv/rafes_back.sv @@
// back end: prefix count store, appends and binary search sequencer
`timescale 1ns / 1ps

module rafes_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rafes_pkg::q_out_t q,
    output logic              pop,
    output rafes_pkg::res_t   res,
    input  logic              res_ready
);
    import rafes_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE_RD,
        ST_BASE_WT,
        ST_PROBE,
        ST_EVAL,
        ST_CMP,
        ST_DONE
    } state_t;

    // prefix count rows 1..MAX_ITEMS; row zero is never stored
    row_t mem [MAX_ITEMS + 1];
    row_t rd_row_reg;
    logic rd_zero_reg;

    state_t                  state_reg;
    logic [IDX_W-1:0]        count_reg;
    row_t                    last_row_reg;
    row_t                    base_row_reg;
    logic [IXW-1:0]          start_reg;
    logic [IXW-1:0]          lo_reg;
    logic [IXW-1:0]          hi_reg;
    logic [IXW-1:0]          probe_reg;
    logic                    final_reg;
    logic [DATA_W-1:0]       thr_reg;
    logic [VALUE_BITS-1:0]   and_reg;
    logic                    found_reg;
    logic [START_W-1:0]      end_reg;

    logic [VALUE_BITS-1:0]   val_ext;
    row_t                    app_row;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        rd_addr;
    logic [IXW:0]            mid_sum;
    logic [IXW-1:0]          probe_now;
    logic [IDX_W-1:0]        len;
    logic [VALUE_BITS-1:0]   and_now;
    logic                    ge;
    logic                    start_bad;

    assign pop = (state_reg == ST_IDLE) && q.valid;

    assign val_ext = VALUE_BITS'(q.cmd.value);

    always_comb
    begin
        for (int b = 0; b < VALUE_BITS; b++)
        begin
            app_row[b] = last_row_reg[b] + IDX_W'(val_ext[b]);
        end
    end

    // appends beyond a full array are dropped
    assign wr_en   = pop && (q.cmd.kind == CMD_APPEND) && (count_reg < IDX_W'(MAX_ITEMS));
    assign wr_addr = count_reg + 1'b1;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} + 1'b1;
    assign probe_now = (lo_reg < hi_reg) ? mid_sum[IXW:1] : lo_reg;

    always_comb
    begin
        case (state_reg)
            ST_BASE_RD: rd_addr = IDX_W'(start_reg - 1'b1);
            ST_PROBE:   rd_addr = IDX_W'(probe_now);
            default:    rd_addr = '0;
        endcase
    end

    // a bit survives the and when every value in the range has it set
    assign len = IDX_W'(probe_reg - start_reg + 1'b1);

    always_comb
    begin
        for (int b = 0; b < VALUE_BITS; b++)
        begin
            and_now[b] = ((rd_row_reg[b] - base_row_reg[b]) == len);
        end
    end

    assign ge = (CMP_W'(and_reg) >= CMP_W'(thr_reg));

    assign start_bad = (q.cmd.start == '0) || (IXW'(q.cmd.start) > IXW'(count_reg));

    assign res.valid     = (state_reg == ST_DONE);
    assign res.found     = found_reg;
    assign res.end_index = end_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= app_row;
        end
        rd_row_reg  <= mem[rd_addr];
        rd_zero_reg <= (rd_addr == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            last_row_reg <= '0;
            base_row_reg <= '0;
            start_reg    <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            probe_reg    <= '0;
            final_reg    <= 1'b0;
            thr_reg      <= '0;
            and_reg      <= '0;
            found_reg    <= 1'b0;
            end_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        case (q.cmd.kind)
                            CMD_CLEAR:
                            begin
                                count_reg    <= '0;
                                last_row_reg <= '0;
                            end
                            CMD_APPEND:
                            begin
                                if (wr_en)
                                begin
                                    count_reg    <= wr_addr;
                                    last_row_reg <= app_row;
                                end
                            end
                            CMD_QUERY:
                            begin
                                start_reg <= IXW'(q.cmd.start);
                                lo_reg    <= IXW'(q.cmd.start);
                                hi_reg    <= IXW'(count_reg);
                                thr_reg   <= q.cmd.threshold;
                                if (start_bad)
                                begin
                                    found_reg <= 1'b0;
                                    end_reg   <= '0;
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    state_reg <= ST_BASE_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_BASE_RD:
                begin
                    state_reg <= ST_BASE_WT;
                end
                ST_BASE_WT:
                begin
                    base_row_reg <= rd_zero_reg ? '0 : rd_row_reg;
                    state_reg    <= ST_PROBE;
                end
                ST_PROBE:
                begin
                    probe_reg <= probe_now;
                    final_reg <= !(lo_reg < hi_reg);
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    and_reg   <= and_now;
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (final_reg)
                    begin
                        found_reg <= ge;
                        end_reg   <= ge ? START_W'(probe_reg) : '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        if (ge)
                        begin
                            lo_reg <= probe_reg;
                        end
                        else
                        begin
                            hi_reg <= probe_reg - 1'b1;
                        end
                        state_reg <= ST_PROBE;
                    end
                end
                ST_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/rafes_checker.sv @@
// port-level checks for the range and farthest end search unit, with bind
`timescale 1ns / 1ps

module rafes_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_found,
    input logic [rafes_pkg::START_W-1:0] rsp_end_index
);
    import rafes_pkg::*;

`include "range_and_farthest_end_search_unit_assert.svh"

    // a response stays offered until taken
    `RAFES_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    // a miss always reports end zero
    `RAFES_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_found, rsp_end_index == '0)

    // a hit names a real one-based end
    `RAFES_ASSERT_NOW(a_hit_nonzero, rsp_valid && rsp_found, rsp_end_index != '0)

    // the end never passes the array capacity
    `RAFES_ASSERT_NOW(a_end_range, rsp_valid, 32'(rsp_end_index) <= MAX_ITEMS)

endmodule

bind range_and_farthest_end_search_unit rafes_checker u_rafes_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_found     (rsp.found),
    .rsp_end_index (rsp.end_index)
);

@@ tb/range_and_farthest_end_search_unit_tb.sv @@
// self-checking testbench for the range and farthest end search unit
`timescale 1ns / 1ps

module range_and_farthest_end_search_unit_tb;
    import rafes_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int ITEM_TARGET = 1750;
    // longest response hold-off of the stall test, in cycles
    localparam int LONG_HOLD   = 400;
    // quiet cycles after the last response, above the longest search
    localparam int TAIL_CYCLES = 64;
    localparam int DRAIN_LIMIT = 20000;

    // what one query should answer
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] end_index;
    } answer_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rafes_req_if req_ch ();
    rafes_rsp_if rsp_ch ();

    range_and_farthest_end_search_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow of the stored array and its length
    logic [DATA_W-1:0] stored_values [1:MAX_ITEMS];
    int unsigned       stored_count = 0;

    // answers owed by the block, oldest first
    answer_t pending_answers [$];

    int unsigned failures         = 0;
    int unsigned items_sent       = 0;
    // idling switches, cleared for stretches of back-to-back traffic
    bit          sender_idle      = 1'b1;
    bit          receiver_idle    = 1'b1;
    // set by a test to make the response side hold off once, for that many cycles
    int unsigned long_hold_cycles = 0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // bitwise and of stored values s..e, both inside the array
    function automatic logic [DATA_W-1:0] and_over(input int unsigned s, input int unsigned e);
        logic [DATA_W-1:0] acc;
        acc = '1;
        for (int unsigned i = s; i <= e; i++)
            acc &= stored_values[i];
        return acc;
    endfunction

    // farthest end whose running and from s stays at or above k; the and only
    // shrinks as the end moves right, so a forward walk stops at the first miss
    function automatic answer_t farthest_end(input logic [START_W-1:0] s,
                                             input logic [DATA_W-1:0] k);
        answer_t           ans;
        logic [DATA_W-1:0] acc;
        int unsigned       e;
        bit                done;
        ans  = '0;
        acc  = '1;
        done = 1'b0;
        if (s < 1 || s > stored_count)
            return ans;
        e = 32'(s);
        while (!done && e <= stored_count)
        begin
            acc &= stored_values[e];
            if (acc < k)
                done = 1'b1;
            else
            begin
                ans.found     = 1'b1;
                ans.end_index = START_W'(e);
                e++;
            end
        end
        return ans;
    endfunction

    // apply one accepted transaction to the shadow state
    task automatic track_transaction(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v,
                                     input logic [START_W-1:0] s, input logic [DATA_W-1:0] k);
        case (m)
            MODE_NEW:
                stored_count = 0;
            MODE_APPEND:
                // a full array drops the value
                if (stored_count < MAX_ITEMS)
                begin
                    stored_count++;
                    stored_values[stored_count] = v;
                end
            MODE_QUERY:
                pending_answers.push_back(farthest_end(s, k));
            default:
                ;  // unused mode is ignored
        endcase
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one transaction after a random gap and hold it until accepted;
    // called right after a rising edge, returns right after the accepting edge
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v,
                             input logic [START_W-1:0] s, input logic [DATA_W-1:0] k);
        int unsigned gap;
        gap = sender_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= m;
        req_ch.value       <= v;
        req_ch.start_index <= s;
        req_ch.threshold   <= k;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        track_transaction(m, v, s, k);
        if (m != MODE_UNUSED)
            items_sent++;
    endtask

    // hold the request side until every owed answer is in and the block is quiet
    task automatic wait_for_drain();
        int unsigned n;
        n = 0;
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (pending_answers.size() != 0)
        begin
            $display("%0t: %0d answers never arrived", $time, pending_answers.size());
            failures++;
            pending_answers.delete();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // array content: mostly dense words so that ands survive long ranges
    function automatic logic [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
            5, 6:          return $urandom;
            7:             return '1;
            8:             return '0;
            default:       return $urandom | 32'h8000_0000;
        endcase
    endfunction

    // threshold near the and of some real range, or fully random
    function automatic logic [DATA_W-1:0] draw_threshold(input int unsigned s);
        logic [DATA_W-1:0] a;
        if (s < 1 || s > stored_count)
            return $urandom;
        a = and_over(s, $urandom_range(s, stored_count));
        case ($urandom_range(0, 6))
            0, 1:    return a;
            2:       return (a == '1) ? a : a + 1'b1;
            3:       return (a == '0) ? a : a - 1'b1;
            4:       return $urandom;
            5:       return '0;
            default: return '1;
        endcase
    endfunction

    // start mostly inside the array, sometimes outside on either side
    function automatic logic [START_W-1:0] draw_start();
        if (stored_count > 0 && $urandom_range(0, 6) != 0)
            return START_W'($urandom_range(1, stored_count));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return START_W'(stored_count + 1);
            2:       return '1;
            default: return START_W'($urandom_range(0, (1 << START_W) - 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes, every mode and each corner of the search, in a short fixed run
    task automatic test_directed_cases();
        // empty array straight after reset
        send_item(MODE_QUERY, '0, 11'd1, '0);
        send_item(MODE_UNUSED, '1, '1, '1);
        send_item(MODE_APPEND, 32'hFFFF_FFFF, '0, '0);
        send_item(MODE_APPEND, 32'hFFFF_FFFF, '1, '1);
        send_item(MODE_APPEND, 32'h8000_0001, '0, '0);
        send_item(MODE_APPEND, 32'h8000_0000, '0, '0);
        send_item(MODE_APPEND, 32'h0000_0000, '0, '0);
        // zero threshold always reaches the last element
        send_item(MODE_QUERY, '0, 11'd1, 32'h0000_0000);
        send_item(MODE_QUERY, '0, 11'd1, 32'hFFFF_FFFF);
        // top bit set: compare must be unsigned
        send_item(MODE_QUERY, '1, 11'd1, 32'h8000_0000);
        send_item(MODE_QUERY, '0, 11'd3, 32'h8000_0001);
        // single element below threshold, then at threshold
        send_item(MODE_QUERY, '0, 11'd5, 32'h0000_0001);
        send_item(MODE_QUERY, '0, 11'd5, 32'h0000_0000);
        // start outside the array: zero, one past the end, all ones
        send_item(MODE_QUERY, '0, 11'd0, 32'h0000_0000);
        send_item(MODE_QUERY, '0, 11'd6, 32'h0000_0000);
        send_item(MODE_QUERY, '0, '1, 32'h0000_0000);
        send_item(MODE_UNUSED, 32'h1234_5678, 11'd2, '0);
        // new array forgets the old contents
        send_item(MODE_NEW, '1, '1, '1);
        send_item(MODE_QUERY, '0, 11'd1, 32'h0000_0000);
        send_item(MODE_APPEND, 32'h0000_0001, '0, '0);
        send_item(MODE_QUERY, '0, 11'd1, 32'h0000_0001);
        send_item(MODE_QUERY, '0, 11'd1, 32'h0000_0002);
        wait_for_drain();
    endtask

    // response side held off for a long stretch while queries keep coming,
    // so the command queue and response register fill and req stalls
    task automatic test_stalled_responses();
        logic [START_W-1:0] s;
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        send_item(MODE_NEW, $urandom, START_W'($urandom), $urandom);
        repeat (40) send_item(MODE_APPEND, draw_value(), START_W'($urandom), $urandom);
        long_hold_cycles = LONG_HOLD;
        repeat (24)
        begin
            s = draw_start();
            send_item(MODE_QUERY, $urandom, s, draw_threshold(32'(s)));
        end
        wait_for_drain();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    // fill the array to capacity, check that further appends are dropped,
    // and search across the whole depth
    task automatic test_full_array();
        logic [START_W-1:0] s;
        send_item(MODE_NEW, $urandom, START_W'($urandom), $urandom);
        sender_idle = 1'b0;
        for (int i = 0; i < MAX_ITEMS; i++)
            send_item(MODE_APPEND, ($urandom_range(0, 9) != 0) ? 32'hFFFF_FFFF : draw_value(),
                      START_W'($urandom), $urandom);
        sender_idle = 1'b1;
        // dropped: would make the last element zero
        repeat (3) send_item(MODE_APPEND, '0, START_W'($urandom), $urandom);
        send_item(MODE_QUERY, $urandom, 11'd1, 32'h0000_0000);
        send_item(MODE_QUERY, $urandom, START_W'(MAX_ITEMS), 32'h0000_0000);
        send_item(MODE_QUERY, $urandom, START_W'(MAX_ITEMS), 32'hFFFF_FFFF);
        send_item(MODE_QUERY, $urandom, START_W'(MAX_ITEMS - 1), 32'hFFFF_FFFF);
        send_item(MODE_QUERY, $urandom, START_W'(MAX_ITEMS + 1), 32'h0000_0000);
        repeat (30)
        begin
            s = draw_start();
            send_item(MODE_QUERY, $urandom, s, draw_threshold(32'(s)));
        end
        wait_for_drain();
    endtask

    // mostly well-formed runs: new array, appends, queries with random content;
    // the rest is stray unused modes, bad starts and runs that skip the new array
    task automatic test_random_sequences();
        int unsigned        len;
        int unsigned        nq;
        logic [START_W-1:0] s;
        while (items_sent < ITEM_TARGET)
        begin
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) != 0)
                send_item(MODE_NEW, $urandom, START_W'($urandom), $urandom);
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(60, 300);
                1:       len = 0;
                default: len = $urandom_range(1, 30);
            endcase
            repeat (len)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(MODE_UNUSED, $urandom, START_W'($urandom), $urandom);
                send_item(MODE_APPEND, draw_value(), START_W'($urandom), $urandom);
            end
            nq = $urandom_range(2, 12);
            repeat (nq)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(MODE_UNUSED, $urandom, START_W'($urandom), $urandom);
                s = draw_start();
                send_item(MODE_QUERY, $urandom, s, draw_threshold(32'(s)));
            end
        end
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // response side: random stalls, and a compare of every transaction
    // against the oldest owed answer
    // ------------------------------------------------------------------
    initial
    begin : response_checker
        int unsigned stall;
        answer_t     want;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = receiver_idle ? $urandom_range(0, 10) : 0;
            if (long_hold_cycles > 0)
            begin
                stall            = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, got found=%0b end_index=%0d",
                         $time, rsp_ch.found, rsp_ch.end_index);
                failures++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp_ch.found !== want.found)
                begin
                    $display("%0t: found mismatch, expected %0b, got %0b",
                             $time, want.found, rsp_ch.found);
                    failures++;
                end
                if (rsp_ch.end_index !== want.end_index)
                begin
                    $display("%0t: end_index mismatch, expected %0d, got %0d",
                             $time, want.end_index, rsp_ch.end_index);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= MODE_NEW;
        req_ch.value       <= '0;
        req_ch.start_index <= '0;
        req_ch.threshold   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_stalled_responses();
        test_full_array();
        test_random_sequences();

        if (failures == 0)
            $display("[range_and_farthest_end_search_unit] OK");
        else
            $display("[range_and_farthest_end_search_unit] ERROR");
        $finish;
    end

    // safety net against a hung handshake
    initial
    begin
        #2_500_000;
        $display("[range_and_farthest_end_search_unit] ERROR");
        $finish;
    end

endmodule
